>>> design/ack_tracking_retransmit_scheduler_macros.svh
`ifndef ACK_TRACKING_RETRANSMIT_SCHEDULER_MACROS_SVH
`define ACK_TRACKING_RETRANSMIT_SCHEDULER_MACROS_SVH

// Checks sampled on clk_i, off while rst_ni is low.
`define ATRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ATRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ATRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/atrs_pkg.sv
`timescale 1ns / 1ps

package atrs_pkg;

  localparam int KIND_W     = 2;
  localparam int SEQ_W      = 16;
  localparam int ACT_W      = 3;
  localparam int PNUM_W     = 12;
  localparam int BYTES_W    = 10;
  localparam int OFS_W      = 22;
  localparam int DCNT_W     = 13;
  localparam int FCNT_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_NACK  = 2'd1,
    KIND_SLOT  = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 3'd0,
    ACT_DATA = 3'd1,
    ACT_FEC  = 3'd2,
    ACT_META = 3'd3,
    ACT_DONE = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_CNT   = 2'd0,
    REG_FEC_CNT    = 2'd1,
    REG_LAST_BYTES = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_PREV  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

endpackage

>>> design/ack_tracking_retransmit_scheduler.sv
`timescale 1ns / 1ps
`include "ack_tracking_retransmit_scheduler_macros.svh"
// Selective-repeat transmit scheduler over a ring of data and FEC packets.
// Input channel (in_valid_i / in_stall_o) takes one command per transfer:
// ack, nack, send slot or start. Output channel (out_valid_o / out_stall_i)
// returns exactly one result per command, in order.
// Config port (cfg_valid_i / cfg_ready_o) is always ready; sizes written there
// are latched by the next start command.
// Ring links and acked marks live in two single-port synchronous RAMs
// (next link + acked mark, prev link). An ack below total reads the entry and
// writes its acked mark back; a send slot reads both links of the current entry,
// and if that entry is acked it also reads the predecessor's acked mark and
// rewrites the links to unlink it. Nack, start, ack of or above total, a slot on
// an empty ring and any command after done touch no RAM. A new command is taken
// only once the previous one has moved its result to the output register;
// the result register lets the next command start while a result waits.
// Reset and each start command run a link init sweep over all total ring entries
// (total = data + fec packets, capped at MAX_PACKETS), during which in_stall_o
// is high. A start's result is produced before its sweep.
// When out_stall_i holds the result register full, the block finishes the
// current command internally and waits before presenting the next result.
module ack_tracking_retransmit_scheduler #(
  parameter int MAX_PACKETS = 4096,
  parameter int CHUNK_BYTES = 1020
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [atrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [atrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [atrs_pkg::KIND_W-1:0]     kind_i,
  input  logic [atrs_pkg::SEQ_W-1:0]      ack_seq_i,
  input  logic                            fec_ready_i,
  input  logic                            link_has_room_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [atrs_pkg::ACT_W-1:0]      action_o,
  output logic [atrs_pkg::PNUM_W-1:0]     packet_number_o,
  output logic [atrs_pkg::BYTES_W-1:0]    payload_bytes_o,
  output logic [atrs_pkg::OFS_W-1:0]      source_offset_o
);
  import atrs_pkg::*;

  localparam int AW = $clog2(MAX_PACKETS);
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam logic [BYTES_W-1:0] RST_LAST =
    (1020 > CHUNK_BYTES) ? BYTES_W'(CHUNK_BYTES) : BYTES_W'(1020);

  // link RAMs
  logic [AW:0]   next_mem [MAX_PACKETS];
  logic [AW-1:0] prev_mem [MAX_PACKETS];
  logic          next_we, next_re, prev_we, prev_re;
  logic [AW-1:0] next_waddr, next_raddr, prev_waddr, prev_raddr;
  logic [AW:0]   next_wdata, next_rdata_q;
  logic [AW-1:0] prev_wdata, prev_rdata_q;

  // config and latched run sizes
  logic [DCNT_W-1:0]  cfg_data_cnt_q;
  logic [FCNT_W-1:0]  cfg_fec_cnt_q;
  logic [BYTES_W-1:0] cfg_last_q;
  logic [CW-1:0]      run_total_q, run_total_d, run_data_q, run_data_d;
  logic [BYTES_W-1:0] run_last_q, run_last_d;

  // control
  state_e        state_q, state_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [CW-1:0] outst_q, outst_d;
  logic          done_q, done_d;
  logic [CW-1:0] sweep_q, sweep_d;
  logic          sweep_pend_q, sweep_pend_d;
  logic          out_valid_q, out_valid_d;

  // per-command payload
  kind_e         op_kind_q, op_kind_d;
  logic [AW-1:0] seq_idx_q, seq_idx_d;
  logic          fec_ok_q, fec_ok_d, room_q, room_d;
  logic [AW-1:0] n_q, n_d, p_q, p_d;
  action_e            res_action_q, res_action_d;
  logic [PNUM_W-1:0]  res_pnum_q, res_pnum_d;
  logic [BYTES_W-1:0] res_bytes_q, res_bytes_d;
  logic [OFS_W-1:0]   res_ofs_q, res_ofs_d;
  action_e            out_action_q;
  logic [PNUM_W-1:0]  out_pnum_q;
  logic [BYTES_W-1:0] out_bytes_q;
  logic [OFS_W-1:0]   out_ofs_q;

  logic               in_accept, out_free, out_load;
  logic [DCNT_W:0]    cnt_sum;
  logic [CW-1:0]      total_new, data_new;
  logic [BYTES_W-1:0] last_new;
  logic [CW-1:0]      sweep_nx;
  logic [AW-1:0]      ofs_idx;
  logic [31:0]        ofs_prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // sizes a start command latches
  always_comb begin
    cnt_sum   = {1'b0, cfg_data_cnt_q} + (DCNT_W + 1)'(cfg_fec_cnt_q);
    total_new = (32'(cnt_sum) > 32'(MAX_PACKETS)) ? CW'(MAX_PACKETS) : CW'(cnt_sum);
    data_new  = (32'(cfg_data_cnt_q) > 32'(total_new)) ? total_new : CW'(cfg_data_cnt_q);
    last_new  = (cfg_last_q == '0 || 32'(cfg_last_q) > 32'(CHUNK_BYTES)) ?
                BYTES_W'(CHUNK_BYTES) : cfg_last_q;
  end

  always_comb begin
    state_d      = state_q;
    run_total_d  = run_total_q;
    run_data_d   = run_data_q;
    run_last_d   = run_last_q;
    cur_d        = cur_q;
    outst_d      = outst_q;
    done_d       = done_q;
    sweep_d      = sweep_q;
    sweep_pend_d = sweep_pend_q;
    op_kind_d    = op_kind_q;
    seq_idx_d    = seq_idx_q;
    fec_ok_d     = fec_ok_q;
    room_d       = room_q;
    n_d          = n_q;
    p_d          = p_q;
    res_action_d = res_action_q;
    res_pnum_d   = res_pnum_q;
    res_bytes_d  = res_bytes_q;
    res_ofs_d    = res_ofs_q;
    next_we      = 1'b0;
    next_waddr   = cur_q;
    next_wdata   = '0;
    next_re      = 1'b0;
    next_raddr   = cur_q;
    prev_we      = 1'b0;
    prev_waddr   = cur_q;
    prev_wdata   = '0;
    prev_re      = 1'b0;
    prev_raddr   = cur_q;
    out_load     = 1'b0;
    sweep_nx     = sweep_q + 1'b1;
    ofs_idx      = cur_q;
    ofs_prod     = '0;

    case (state_q)
      ST_SWEEP: begin
        if (run_total_q != '0) begin
          next_we    = 1'b1;
          next_waddr = AW'(sweep_q);
          next_wdata = {1'b0, (sweep_nx == run_total_q) ? AW'(0) : AW'(sweep_nx)};
          prev_we    = 1'b1;
          prev_waddr = AW'(sweep_q);
          prev_wdata = (sweep_q == '0) ? AW'(run_total_q - 1'b1) : AW'(sweep_q - 1'b1);
        end
        sweep_d = sweep_nx;
        if (run_total_q == '0 || sweep_q == run_total_q - 1'b1) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          op_kind_d    = kind_e'(kind_i);
          seq_idx_d    = ack_seq_i[AW-1:0];
          fec_ok_d     = fec_ready_i;
          room_d       = link_has_room_i;
          res_action_d = ACT_NONE;
          res_pnum_d   = '0;
          res_bytes_d  = '0;
          res_ofs_d    = '0;
          state_d      = ST_EMIT;
          if (kind_e'(kind_i) == KIND_START) begin
            run_total_d  = total_new;
            run_data_d   = data_new;
            run_last_d   = last_new;
            cur_d        = '0;
            outst_d      = total_new;
            done_d       = 1'b0;
            sweep_d      = '0;
            sweep_pend_d = 1'b1;
            res_action_d = ACT_META;
          end else if (!done_q) begin
            case (kind_e'(kind_i))
              KIND_ACK: begin
                if (32'(ack_seq_i) == 32'(run_total_q)) begin
                  done_d       = 1'b1;
                  res_action_d = ACT_DONE;
                end else if (32'(ack_seq_i) < 32'(run_total_q)) begin
                  next_re    = 1'b1;
                  next_raddr = ack_seq_i[AW-1:0];
                  state_d    = ST_READ;
                end
              end
              KIND_NACK: res_action_d = ACT_META;
              KIND_SLOT: begin
                if (run_total_q != '0 && 32'(cur_q) < 32'(run_total_q)) begin
                  next_re = 1'b1;
                  prev_re = 1'b1;
                  state_d = ST_READ;
                end else begin
                  done_d       = 1'b1;
                  res_action_d = ACT_DONE;
                end
              end
              default: res_action_d = ACT_NONE;
            endcase
          end
        end
      end

      ST_READ: begin
        state_d = ST_EMIT;
        if (op_kind_q == KIND_ACK) begin
          if (!next_rdata_q[AW] && outst_q != '0) outst_d = outst_q - 1'b1;
          next_we    = 1'b1;
          next_waddr = seq_idx_q;
          next_wdata = {1'b1, next_rdata_q[AW-1:0]};
        end else begin
          if (next_rdata_q[AW]) begin
            // acked: unlink, but first fetch the predecessor's acked mark
            cur_d      = next_rdata_q[AW-1:0];
            n_d        = next_rdata_q[AW-1:0];
            p_d        = prev_rdata_q;
            next_re    = 1'b1;
            next_raddr = prev_rdata_q;
            state_d    = ST_PREV;
          end else if (32'(cur_q) >= 32'(run_data_q) && !fec_ok_q) begin
            cur_d = next_rdata_q[AW-1:0];
          end else begin
            res_pnum_d = PNUM_W'(cur_q);
            if (32'(cur_q) < 32'(run_data_q)) begin
              res_action_d = ACT_DATA;
              res_bytes_d  = (32'(cur_q) + 32'd1 == 32'(run_data_q)) ?
                             run_last_q : BYTES_W'(CHUNK_BYTES);
              ofs_idx      = cur_q;
            end else begin
              res_action_d = ACT_FEC;
              res_bytes_d  = BYTES_W'(CHUNK_BYTES);
              ofs_idx      = cur_q - AW'(run_data_q);
            end
            ofs_prod  = 32'(ofs_idx) * 32'(CHUNK_BYTES);
            res_ofs_d = ofs_prod[OFS_W-1:0];
            if (room_q) cur_d = next_rdata_q[AW-1:0];
          end
          if (outst_q == '0) begin
            done_d       = 1'b1;
            res_action_d = ACT_DONE;
            res_pnum_d   = '0;
            res_bytes_d  = '0;
            res_ofs_d    = '0;
          end
        end
      end

      ST_PREV: begin
        next_we    = 1'b1;
        next_waddr = p_q;
        next_wdata = {next_rdata_q[AW], n_q};
        prev_we    = 1'b1;
        prev_waddr = n_q;
        prev_wdata = p_q;
        state_d    = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          sweep_pend_d = 1'b0;
          state_d      = sweep_pend_q ? ST_SWEEP : ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_data_cnt_q <= DCNT_W'(1);
      cfg_fec_cnt_q  <= '0;
      cfg_last_q     <= BYTES_W'(1020);
      run_total_q    <= CW'(1);
      run_data_q     <= CW'(1);
      run_last_q     <= RST_LAST;
      state_q        <= ST_SWEEP;
      cur_q          <= '0;
      outst_q        <= CW'(1);
      done_q         <= 1'b0;
      sweep_q        <= '0;
      sweep_pend_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_DATA_CNT:   cfg_data_cnt_q <= cfg_data_i;
          REG_FEC_CNT:    cfg_fec_cnt_q  <= cfg_data_i[FCNT_W-1:0];
          REG_LAST_BYTES: cfg_last_q     <= cfg_data_i[BYTES_W-1:0];
          default: ;
        endcase
      end
      run_total_q  <= run_total_d;
      run_data_q   <= run_data_d;
      run_last_q   <= run_last_d;
      state_q      <= state_d;
      cur_q        <= cur_d;
      outst_q      <= outst_d;
      done_q       <= done_d;
      sweep_q      <= sweep_d;
      sweep_pend_q <= sweep_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_kind_q    <= op_kind_d;
    seq_idx_q    <= seq_idx_d;
    fec_ok_q     <= fec_ok_d;
    room_q       <= room_d;
    n_q          <= n_d;
    p_q          <= p_d;
    res_action_q <= res_action_d;
    res_pnum_q   <= res_pnum_d;
    res_bytes_q  <= res_bytes_d;
    res_ofs_q    <= res_ofs_d;
    if (out_load) begin
      out_action_q <= res_action_q;
      out_pnum_q   <= res_pnum_q;
      out_bytes_q  <= res_bytes_q;
      out_ofs_q    <= res_ofs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (next_re) next_rdata_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (prev_re) prev_rdata_q <= prev_mem[prev_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_action_q;
  assign packet_number_o = out_pnum_q;
  assign payload_bytes_o = out_bytes_q;
  assign source_offset_o = out_ofs_q;

  `ATRS_ASSERT(a_outst_le_total, outst_q <= run_total_q, "outstanding count above total")
  `ATRS_ASSERT_IMP(a_cur_in_ring, (state_q == ST_IDLE) && (run_total_q != '0), cur_q < run_total_q, "current entry outside ring")
  `ATRS_ASSERT_IMP(a_no_ram_write_idle, (state_q == ST_IDLE) || (state_q == ST_EMIT), !next_we && !prev_we, "link RAM written outside a command")
  `ATRS_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT) && out_free, out_valid_q, "result not presented after emit")

endmodule

>>> dv/tb_ack_tracking_retransmit_scheduler.sv
`timescale 1ns / 1ps

module tb_ack_tracking_retransmit_scheduler;
  import atrs_pkg::*;

  localparam int MAX_PKT     = 4096;
  localparam int CHUNK       = 1020;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    action_e              action;
    logic [PNUM_W-1:0]    pnum;
    logic [BYTES_W-1:0]   bytes;
    logic [OFS_W-1:0]     ofs;
  } sched_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i;
  logic [SEQ_W-1:0]      ack_seq_i;
  logic                  fec_ready_i;
  logic                  link_has_room_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ACT_W-1:0]      action_o;
  logic [PNUM_W-1:0]     packet_number_o;
  logic [BYTES_W-1:0]    payload_bytes_o;
  logic [OFS_W-1:0]      source_offset_o;

  ack_tracking_retransmit_scheduler DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .ack_seq_i       (ack_seq_i),
    .fec_ready_i     (fec_ready_i),
    .link_has_room_i (link_has_room_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .packet_number_o (packet_number_o),
    .payload_bytes_o (payload_bytes_o),
    .source_offset_o (source_offset_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the scheduler: registers, latched sizes and the ring.
  logic [DCNT_W-1:0]  sh_data_cnt;
  logic [FCNT_W-1:0]  sh_fec_cnt;
  logic [BYTES_W-1:0] sh_last_bytes;
  bit                 ring_acked [MAX_PKT];
  int unsigned        ring_next  [MAX_PKT];
  int unsigned        ring_prev  [MAX_PKT];
  int unsigned        ring_cur;
  int unsigned        pkts_left;
  int unsigned        run_total;
  int unsigned        run_data;
  int unsigned        run_last;
  bit                 run_done;

  sched_result_t expected_q[$];
  sched_result_t want_r;
  int            mismatches = 0;
  int            items_sent;
  int            cycles = 0;
  bit            idle_on;
  int            stall_hold;
  int            burst_left = 0;

  function automatic void load_ring();
    int unsigned tot;
    tot = int'(sh_data_cnt) + int'(sh_fec_cnt);
    if (tot > MAX_PKT) tot = MAX_PKT;
    run_total = tot;
    run_data  = (int'(sh_data_cnt) > tot) ? tot : int'(sh_data_cnt);
    run_last  = (sh_last_bytes == 0 || sh_last_bytes > CHUNK) ? CHUNK : int'(sh_last_bytes);
    for (int i = 0; i < MAX_PKT; i++) ring_acked[i] = 1'b0;
    for (int unsigned i = 0; i < tot; i++) begin
      ring_next[i] = (i + 1 == tot) ? 0 : i + 1;
      ring_prev[i] = (i == 0) ? tot - 1 : i - 1;
    end
    ring_cur  = 0;
    pkts_left = tot;
    run_done  = 1'b0;
  endfunction

  function automatic sched_result_t predict_item(kind_e k, logic [SEQ_W-1:0] seq,
                                                 bit fec, bit room);
    sched_result_t r;
    int unsigned   c, n, p;
    r = '{ACT_NONE, '0, '0, '0};
    if (k == KIND_START) begin
      load_ring();
      r.action = ACT_META;
    end else if (!run_done) begin
      case (k)
        KIND_ACK: begin
          if (seq == run_total) begin
            run_done = 1'b1;
            r.action = ACT_DONE;
          end else if (seq < run_total) begin
            if (!ring_acked[seq] && pkts_left > 0) pkts_left--;
            ring_acked[seq] = 1'b1;
          end
        end
        KIND_NACK: r.action = ACT_META;
        default: begin
          if (run_total > 0 && ring_cur < run_total) begin
            c = ring_cur;
            if (ring_acked[c]) begin
              // acked entry drops out of the ring, nothing goes out
              n = ring_next[c] % run_total;
              p = ring_prev[c] % run_total;
              ring_next[p] = n;
              ring_prev[n] = p;
              ring_cur = n;
            end else if (c >= run_data && !fec) begin
              ring_cur = ring_next[c] % run_total;
            end else begin
              r.pnum = c[PNUM_W-1:0];
              if (c < run_data) begin
                r.action = ACT_DATA;
                r.bytes  = (c + 1 == run_data) ? run_last[BYTES_W-1:0] : CHUNK[BYTES_W-1:0];
                r.ofs    = OFS_W'(c * CHUNK);
              end else begin
                r.action = ACT_FEC;
                r.bytes  = CHUNK[BYTES_W-1:0];
                r.ofs    = OFS_W'((c - run_data) * CHUNK);
              end
              if (room) ring_cur = ring_next[c] % run_total;
            end
            if (pkts_left == 0) begin
              run_done = 1'b1;
              r = '{ACT_DONE, '0, '0, '0};
            end
          end else begin
            run_done = 1'b1;
            r.action = ACT_DONE;
          end
        end
      endcase
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: action %0d pkt %0d bytes %0d ofs %0d",
                   action_o, packet_number_o, payload_bytes_o, source_offset_o);
        mismatches++;
      end else begin
        want_r = expected_q.pop_front();
        if (action_o !== want_r.action || packet_number_o !== want_r.pnum ||
            payload_bytes_o !== want_r.bytes || source_offset_o !== want_r.ofs) begin
          if (mismatches < 10)
            $display("mismatch: exp action %0d pkt %0d bytes %0d ofs %0d, got %0d %0d %0d %0d",
                     want_r.action, want_r.pnum, want_r.bytes, want_r.ofs,
                     action_o, packet_number_o, payload_bytes_o, source_offset_o);
          mismatches++;
        end
      end
    end
  end

  // receiver: long hold-off on request, random stall bursts otherwise while idle_on is set
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold > 0) begin
        stall_hold--;
        out_stall_i <= 1'b1;
      end else if (idle_on && burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        burst_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ack_tracking_retransmit_scheduler");
      $finish;
    end
  end

  task automatic send_item(input kind_e k, input logic [SEQ_W-1:0] seq,
                           input bit fec, input bit room);
    bit ignored;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    ack_seq_i       <= seq;
    fec_ready_i     <= fec;
    link_has_room_i <= room;
    do @(posedge clk_i); while (in_stall_o);
    ignored = run_done && (k != KIND_START);
    expected_q.push_back(predict_item(k, seq, fec, room));
    if (!ignored) items_sent++;
  endtask

  // drain results, then let any link init sweep finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (run_total + 40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DATA_CNT:   sh_data_cnt   = val[DCNT_W-1:0];
      REG_FEC_CNT:    sh_fec_cnt    = val[FCNT_W-1:0];
      REG_LAST_BYTES: sh_last_bytes = val[BYTES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input int unsigned d, input int unsigned f, input int unsigned l);
    wait_idle();
    write_reg(REG_DATA_CNT, CFG_DATA_W'(d));
    write_reg(REG_FEC_CNT, CFG_DATA_W'(f));
    write_reg(REG_LAST_BYTES, CFG_DATA_W'(l));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one transfer: start, then mostly slots and acks of in-range packets, some noise
  task automatic run_transfer(input int unsigned d, input int unsigned f,
                              input int unsigned l, input int budget);
    int          n;
    int unsigned r;
    write_regs(d, f, l);
    send_item(KIND_START, $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
    n = 0;
    while (!run_done && n < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(KIND_SLOT, $urandom_range(0, 65535), $urandom_range(0, 3) != 0,
                  $urandom_range(0, 4) != 0);
      else if (r < 83 && run_total > 0)
        send_item(KIND_ACK, $urandom_range(0, run_total - 1), $urandom_range(0, 1),
                  $urandom_range(0, 1));
      else if (r < 89)
        send_item(KIND_NACK, $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
      else if (r < 95)
        send_item(KIND_ACK, $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
      else if (r < 98)
        send_item(KIND_ACK, SEQ_W'(run_total), $urandom_range(0, 1), $urandom_range(0, 1));
      else
        send_item(KIND_START, $urandom_range(0, 65535), $urandom_range(0, 1),
                  $urandom_range(0, 1));
      n++;
    end
    if ($urandom_range(0, 1)) begin
      send_item(KIND_SLOT, $urandom_range(0, 65535), 1'b1, 1'b1);
      send_item(KIND_NACK, $urandom_range(0, 65535), 1'b0, 1'b0);
    end
  endtask

  // power-up sizes: one data packet of a full chunk
  task automatic test_reset_defaults();
    send_item(KIND_SLOT, 16'h0000, 1'b0, 1'b1);
    send_item(KIND_NACK, 16'hFFFF, 1'b1, 1'b0);
    send_item(KIND_ACK, 16'd9, 1'b0, 1'b0);
    send_item(KIND_ACK, 16'd0, 1'b0, 1'b0);
    send_item(KIND_ACK, 16'd0, 1'b1, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    send_item(KIND_NACK, 16'd0, 1'b0, 1'b0);
  endtask

  // refused send, FEC skip while not ready, FEC send, unlink, ack of total
  task automatic test_ring_walk();
    write_regs(3, 2, 7);
    send_item(KIND_START, 16'd0, 1'b0, 1'b0);
    send_item(KIND_SLOT, 16'd0, 1'b0, 1'b0);
    send_item(KIND_SLOT, 16'd0, 1'b0, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b0, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b0, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b0, 1'b1);
    send_item(KIND_ACK, 16'd0, 1'b0, 1'b0);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    send_item(KIND_ACK, 16'd5, 1'b0, 1'b0);
  endtask

  // saturated total, empty ring, FEC-only transfer, unused register index
  task automatic test_size_extremes();
    write_regs(8191, 4095, 1023);
    wait_idle();
    write_reg(REG_UNUSED, 13'h1FFF);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    send_item(KIND_START, 16'hFFFF, 1'b1, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    send_item(KIND_ACK, 16'hFFFF, 1'b0, 1'b0);
    send_item(KIND_ACK, 16'd4096, 1'b0, 1'b0);
    write_regs(0, 0, 1020);
    send_item(KIND_START, 16'd0, 1'b0, 1'b0);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    write_regs(0, 3, 0);
    send_item(KIND_START, 16'd0, 1'b0, 1'b0);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
    send_item(KIND_SLOT, 16'd0, 1'b1, 1'b1);
  endtask

  // receiver holds off while slots keep coming, so the input backs up
  task automatic test_backpressure();
    write_regs(6, 2, 500);
    send_item(KIND_START, 16'd0, 1'b1, 1'b1);
    stall_hold = 300;
    repeat (40) send_item(KIND_SLOT, $urandom_range(0, 65535), 1'b1, 1'b1);
  endtask

  task automatic test_random_transfers();
    int          big_left;
    int unsigned d, f;
    big_left = 3;
    while (items_sent < 1650) begin
      if (big_left > 0 && $urandom_range(0, 19) == 0) begin
        big_left--;
        run_transfer($urandom_range(0, 8191), $urandom_range(0, 4095),
                     $urandom_range(0, 1023), 60);
      end else begin
        d = $urandom_range(0, 24);
        f = $urandom_range(0, 12);
        run_transfer(d, f, $urandom_range(0, 1023), 4 * (d + f) + 10);
      end
    end
  endtask

  task automatic test_full_rate_tail();
    int unsigned d, f;
    idle_on = 1'b0;
    while (items_sent < 1850) begin
      d = $urandom_range(1, 16);
      f = $urandom_range(0, 8);
      run_transfer(d, f, $urandom_range(1, 1020), 4 * (d + f) + 10);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_DATA_CNT;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = KIND_ACK;
    ack_seq_i       = '0;
    fec_ready_i     = 1'b0;
    link_has_room_i = 1'b0;
    items_sent      = 0;
    idle_on         = 1'b1;
    stall_hold      = 0;
    sh_data_cnt     = 13'd1;
    sh_fec_cnt      = 12'd0;
    sh_last_bytes   = 10'd1020;
    load_ring();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_ring_walk();
    test_size_extremes();
    test_backpressure();
    test_random_transfers();
    test_full_rate_tail();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS ack_tracking_retransmit_scheduler");
    end else begin
      $display("FAIL ack_tracking_retransmit_scheduler");
    end
    $finish;
  end

endmodule
